/* design/assert_macros.svh */
// Assertion macros shared by the search core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define HSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset.
`define HSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/hss_pkg.sv */
// Package: constants, codes and types of the Horspool search core.
package hss_pkg;

    // Store sizes
    localparam int NEEDLE_MAX   = 64;
    localparam int HAYSTACK_MAX = 4096;
    localparam int SKIP_DEPTH   = 256;

    // Derived widths
    localparam int NADDR_W = $clog2(NEEDLE_MAX);
    localparam int HADDR_W = $clog2(HAYSTACK_MAX);
    localparam int NLEN_W  = 7;
    localparam int HLEN_W  = 13;
    localparam int SKIP_W  = 7;
    localparam int SADDR_W = $clog2(SKIP_DEPTH);
    localparam int POS_W   = 13;
    localparam int SUM_W   = 14;
    localparam int CFG_W   = 13;

    // Request codes
    localparam logic [1:0] REQ_NEEDLE   = 2'd0;
    localparam logic [1:0] REQ_HAYSTACK = 2'd1;
    localparam logic [1:0] REQ_SEARCH   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_UNSET     = 2'd2;

    // Configuration register indexes
    localparam logic CFG_NEEDLE_LEN   = 1'b0;
    localparam logic CFG_HAYSTACK_LEN = 1'b1;

    // Search sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_CHECK,
        S_CMP,
        S_SKIP_RD,
        S_SKIP_ADD,
        S_DONE
    } state_t;

    // Skip table write beat
    typedef struct packed {
        logic               en;
        logic [SADDR_W-1:0] addr;
        logic [SKIP_W-1:0]  data;
    } skip_wr_t;

endpackage

/* design/hss_skip_table.sv */
// Bad-character skip table: 256-entry memory with per-entry valid bits.
module hss_skip_table
    import hss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  skip_wr_t           wr,
    input  logic               rd_en,
    input  logic [SADDR_W-1:0] rd_addr,
    input  logic [SKIP_W-1:0]  dflt,
    output logic [SKIP_W-1:0]  rd_skip
);

    logic [SKIP_W-1:0]     mem [SKIP_DEPTH];
    logic [SKIP_DEPTH-1:0] vld_reg;
    logic [SKIP_W-1:0]     data_reg;
    logic                  hit_reg;

    // Clear all entries at once, mark written entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (clear)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
            hit_reg  <= vld_reg[rd_addr];
        end
    end

    // Unwritten entry reads as the needle length
    assign rd_skip = hit_reg ? data_reg : dflt;

endmodule

/* design/horspool_substring_search_core.sv */
// Top level: Horspool byte-string search over on-chip needle and haystack stores.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per beat: write a
//   needle byte, write a haystack byte, or search from start_position.
//   Output channel (out_valid / out_stall) carries one beat per search:
//   status and match_position. Byte writes and unused codes give no beat.
//   Lengths are set through the cfg port while no search is running.
// Timing:
//   A byte write is taken whenever the core is idle; writes may follow back to back.
//   A search holds in_stall high for its whole run: it rebuilds the skip
//   table from the needle store (n = needle length), then per window takes a
//   check step, compares bytes (one per cycle through the store read ports)
//   and, on a mismatch, takes a skip read and a skip add step; last it loads
//   the result. A zero length search goes straight to loading the result.
//   The result register sits on the output side, so requests are taken while
//   a result waits; a search that ends while out_stall holds the previous
//   result waits for it to leave.
// Reset: lengths clear to zero, the sequencer returns to idle and any pending
//   result is dropped; store contents are not cleared.
module horspool_substring_search_core
    import hss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    // Request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [HADDR_W-1:0]  byte_index,
    input  logic [7:0]          byte_value,
    input  logic [HADDR_W-1:0]  start_position,
    // Result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [HADDR_W-1:0]  match_position
);

`include "assert_macros.svh"

    state_t              state_reg, state_next;
    logic [NLEN_W-1:0]   needle_length_reg;
    logic [HLEN_W-1:0]   haystack_length_reg;
    logic [NLEN_W-1:0]   n_reg, n_next;
    logic [HLEN_W-1:0]   h_reg, h_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [NLEN_W-1:0]   k_reg, k_next;
    logic [NLEN_W-1:0]   i_reg, i_next;
    logic                more_reg, more_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [NLEN_W-1:0]   cmp_i_reg, cmp_i_next;
    logic                bld_vld_reg, bld_vld_next;
    logic [NLEN_W-1:0]   bld_k_reg, bld_k_next;
    logic [7:0]          last_reg, last_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [HADDR_W-1:0]  res_pos_reg, res_pos_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg, status_next;
    logic [HADDR_W-1:0]  match_position_reg, match_position_next;

    logic [7:0]          needle_mem [NEEDLE_MAX];
    logic [7:0]          hay_mem [HAYSTACK_MAX];
    logic [7:0]          needle_rd_reg;
    logic [7:0]          hay_rd_reg;

    logic                in_accept;
    logic                nd_wr_en;
    logic                hs_wr_en;
    logic                nd_rd_en;
    logic [NADDR_W-1:0]  nd_rd_addr;
    logic                hs_rd_en;
    logic [POS_W-1:0]    hs_sum;
    logic [NLEN_W-1:0]   n_eff;
    logic [HLEN_W-1:0]   h_eff;
    logic [SUM_W-1:0]    win_end;
    logic [SUM_W-1:0]    h_ext;
    logic [SUM_W-1:0]    found_end;
    logic                skip_clear;
    logic                skip_rd_en;
    skip_wr_t            skip_wr;
    logic [SKIP_W-1:0]   skip_val;

    // Handshake and store write enables
    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign nd_wr_en  = in_accept && (req_type == REQ_NEEDLE)
                       && ({1'b0, byte_index} < (HADDR_W + 1)'(NEEDLE_MAX));
    assign hs_wr_en  = in_accept && (req_type == REQ_HAYSTACK)
                       && ({1'b0, byte_index} < (HADDR_W + 1)'(HAYSTACK_MAX));

    // Saturate lengths at the store depths
    assign n_eff = (needle_length_reg > NLEN_W'(NEEDLE_MAX))
                   ? NLEN_W'(NEEDLE_MAX) : needle_length_reg;
    assign h_eff = (haystack_length_reg > HLEN_W'(HAYSTACK_MAX))
                   ? HLEN_W'(HAYSTACK_MAX) : haystack_length_reg;

    // Window bounds
    assign win_end   = SUM_W'(pos_reg) + SUM_W'(n_reg);
    assign h_ext     = SUM_W'(h_reg);
    assign found_end = SUM_W'(res_pos_reg) + SUM_W'(n_reg);
    assign hs_sum    = pos_reg + POS_W'(i_reg);

    // Skip table writes land in the cycle after their needle reads
    assign skip_wr.en   = bld_vld_reg;
    assign skip_wr.addr = needle_rd_reg;
    assign skip_wr.data = SKIP_W'(n_reg - bld_k_reg - NLEN_W'(1));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_length_reg   <= '0;
            haystack_length_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_NEEDLE_LEN:   needle_length_reg   <= cfg_data[NLEN_W-1:0];
                CFG_HAYSTACK_LEN: haystack_length_reg <= cfg_data[HLEN_W-1:0];
                default:          needle_length_reg   <= needle_length_reg;
            endcase
        end
    end

    // Needle store
    always_ff @(posedge clk)
    begin
        if (nd_wr_en)
        begin
            needle_mem[byte_index[NADDR_W-1:0]] <= byte_value;
        end
        if (nd_rd_en)
        begin
            needle_rd_reg <= needle_mem[nd_rd_addr];
        end
    end

    // Haystack store
    always_ff @(posedge clk)
    begin
        if (hs_wr_en)
        begin
            hay_mem[byte_index] <= byte_value;
        end
        if (hs_rd_en)
        begin
            hay_rd_reg <= hay_mem[hs_sum[HADDR_W-1:0]];
        end
    end

    // Skip table
    hss_skip_table u_skip (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (skip_clear),
        .wr      (skip_wr),
        .rd_en   (skip_rd_en),
        .rd_addr (last_reg),
        .dflt    (SKIP_W'(n_reg)),
        .rd_skip (skip_val)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            more_reg      <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            bld_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            more_reg      <= more_next;
            cmp_vld_reg   <= cmp_vld_next;
            bld_vld_reg   <= bld_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        n_reg              <= n_next;
        h_reg              <= h_next;
        pos_reg            <= pos_next;
        k_reg              <= k_next;
        i_reg              <= i_next;
        cmp_i_reg          <= cmp_i_next;
        bld_k_reg          <= bld_k_next;
        last_reg           <= last_next;
        res_status_reg     <= res_status_next;
        res_pos_reg        <= res_pos_next;
        status_reg         <= status_next;
        match_position_reg <= match_position_next;
    end

    // Search sequencer
    always_comb
    begin
        state_next          = state_reg;
        n_next              = n_reg;
        h_next              = h_reg;
        pos_next            = pos_reg;
        k_next              = k_reg;
        i_next              = i_reg;
        more_next           = more_reg;
        cmp_vld_next        = 1'b0;
        cmp_i_next          = cmp_i_reg;
        bld_vld_next        = 1'b0;
        bld_k_next          = bld_k_reg;
        last_next           = last_reg;
        res_status_next     = res_status_reg;
        res_pos_next        = res_pos_reg;
        out_valid_next      = out_valid_reg;
        status_next         = status_reg;
        match_position_next = match_position_reg;
        nd_rd_en            = 1'b0;
        nd_rd_addr          = k_reg[NADDR_W-1:0];
        hs_rd_en            = 1'b0;
        skip_clear          = 1'b0;
        skip_rd_en          = 1'b0;

        // Drop the result beat once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (req_type == REQ_SEARCH))
                begin
                    n_next   = n_eff;
                    h_next   = h_eff;
                    pos_next = POS_W'(start_position);
                    k_next   = '0;
                    if ((n_eff == '0) || (h_eff == '0))
                    begin
                        res_status_next = ST_UNSET;
                        res_pos_next    = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        skip_clear = 1'b1;
                        state_next = S_BUILD;
                    end
                end
            end

            // Walk needle bytes 0 .. n-2 into the skip table
            S_BUILD:
            begin
                if ((k_reg + NLEN_W'(1)) < n_reg)
                begin
                    nd_rd_en     = 1'b1;
                    nd_rd_addr   = k_reg[NADDR_W-1:0];
                    bld_vld_next = 1'b1;
                    bld_k_next   = k_reg;
                    k_next       = k_reg + NLEN_W'(1);
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end

            // Stop when the window runs past the haystack end
            S_CHECK:
            begin
                if (win_end <= h_ext)
                begin
                    i_next     = n_reg - NLEN_W'(1);
                    more_next  = 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_pos_next    = '0;
                    state_next      = S_DONE;
                end
            end

            // Compare from the window's last byte backwards, one byte a cycle
            S_CMP:
            begin
                if (cmp_vld_reg && (cmp_i_reg == (n_reg - NLEN_W'(1))))
                begin
                    last_next = hay_rd_reg;
                end
                if (cmp_vld_reg && (hay_rd_reg != needle_rd_reg))
                begin
                    state_next = S_SKIP_RD;
                end
                else if (cmp_vld_reg && (cmp_i_reg == '0))
                begin
                    res_status_next = ST_FOUND;
                    res_pos_next    = pos_reg[HADDR_W-1:0];
                    state_next      = S_DONE;
                end
                else if (more_reg)
                begin
                    nd_rd_en     = 1'b1;
                    nd_rd_addr   = i_reg[NADDR_W-1:0];
                    hs_rd_en     = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_i_next   = i_reg;
                    if (i_reg == '0)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        i_next = i_reg - NLEN_W'(1);
                    end
                end
            end

            // Look up the skip of the window's last byte
            S_SKIP_RD:
            begin
                skip_rd_en = 1'b1;
                state_next = S_SKIP_ADD;
            end

            // Advance the window
            S_SKIP_ADD:
            begin
                pos_next   = pos_reg + POS_W'(skip_val);
                state_next = S_CHECK;
            end

            // Hold the result until the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    status_next         = res_status_reg;
                    match_position_next = res_pos_reg;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign match_position = match_position_reg;

    // Checks
    `HSS_ASSERT_IMP(a_found_in_range, (state_reg == S_DONE) && (res_status_reg == ST_FOUND), found_end <= h_ext, "found match runs past haystack end")
    `HSS_ASSERT_IMP(a_hay_read_in_window, hs_rd_en, SUM_W'(hs_sum) < h_ext, "haystack read beyond its length")
    `HSS_ASSERT_IMP(a_skip_bounded, state_reg == S_SKIP_ADD, (skip_val != '0) && (skip_val <= SKIP_W'(n_reg)), "skip value out of range")
    `HSS_ASSERT_NXT(a_result_from_done, !out_valid_reg && (state_reg != S_DONE), !out_valid_reg, "result beat without a finished search")

endmodule

/* test/search_checker.sv */
`timescale 1ns / 100ps
// Checker for the Horspool search core: watches both channels, predicts each search and scores it.
module search_checker
    import hss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [HADDR_W-1:0] byte_index,
    input  logic [7:0]         byte_value,
    input  logic [HADDR_W-1:0] start_position,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         status,
    input  logic [HADDR_W-1:0] match_position,
    output int                 searches_open,
    output int                 failures
);

    typedef struct packed {
        logic [1:0]         status;
        logic [HADDR_W-1:0] position;
    } search_outcome_t;

    // Shadow copies of the stores and length registers
    logic [7:0]        needle_mem [NEEDLE_MAX];
    logic [7:0]        hay_mem    [HAYSTACK_MAX];
    logic [NLEN_W-1:0] needle_len;
    logic [HLEN_W-1:0] hay_len;

    // Outcomes of accepted searches, oldest first
    search_outcome_t   outcome_queue [$];
    search_outcome_t   due;

    // Horspool search over the shadow stores, from the given haystack offset
    function automatic search_outcome_t locate_needle(input logic [HADDR_W-1:0] from);
        int unsigned     n;
        int unsigned     h;
        int unsigned     pos;
        int unsigned     i;
        int unsigned     k;
        int unsigned     skip [SKIP_DEPTH];
        bit              hit;
        bit              done;
        search_outcome_t res;

        n = (needle_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(needle_len);
        h = (hay_len > HAYSTACK_MAX) ? HAYSTACK_MAX : int'(hay_len);
        res.status   = ST_NOT_FOUND;
        res.position = '0;
        if (n == 0 || h == 0)
        begin
            res.status = ST_UNSET;
        end
        else
        begin
            // Rebuild the bad-character table from the needle
            for (k = 0; k < SKIP_DEPTH; k++)
                skip[k] = n;
            for (k = 0; k + 1 < n; k++)
                skip[needle_mem[k]] = n - 1 - k;

            // Compare each window from its tail, then advance by the tail byte's skip
            pos  = from;
            done = 1'b0;
            while (!done && pos <= h && h - pos >= n)
            begin
                hit = 1'b1;
                i   = n;
                while (hit && i > 0)
                begin
                    i--;
                    if (hay_mem[pos + i] != needle_mem[i])
                        hit = 1'b0;
                end
                if (hit)
                begin
                    res.status   = ST_FOUND;
                    res.position = HADDR_W'(pos);
                    done         = 1'b1;
                end
                else
                begin
                    pos = pos + skip[hay_mem[pos + n - 1]];
                end
            end
        end
        return res;
    endfunction

    // Track configuration, stores and results beat by beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_len = '0;
            hay_len    = '0;
            failures   = 0;
            outcome_queue.delete();
            searches_open <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_NEEDLE_LEN)
                    needle_len = cfg_data[NLEN_W-1:0];
                else
                    hay_len = cfg_data[HLEN_W-1:0];
            end

            if (in_valid && !in_stall)
            begin
                case (req_type)
                    REQ_NEEDLE:
                    begin
                        if (byte_index < NEEDLE_MAX)
                            needle_mem[byte_index] = byte_value;
                    end
                    REQ_HAYSTACK:
                    begin
                        hay_mem[byte_index] = byte_value;
                    end
                    REQ_SEARCH:
                    begin
                        outcome_queue.push_back(locate_needle(start_position));
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (outcome_queue.size() == 0)
                begin
                    $error("result beat with no search outstanding: status %0d, match_position %0d",
                           status, match_position);
                    failures = failures + 1;
                end
                else
                begin
                    due = outcome_queue.pop_front();
                    if (due.status !== status)
                    begin
                        $error("status: expected %0d, got %0d", due.status, status);
                        failures = failures + 1;
                    end
                    if (due.position !== match_position)
                    begin
                        $error("match_position: expected %0d, got %0d",
                               due.position, match_position);
                        failures = failures + 1;
                    end
                end
            end

            searches_open <= outcome_queue.size();
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Top of the Horspool search core testbench: clock, reset, request and result traffic, verdict.
module testbench;
    import hss_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_ITEMS = 2000;

    // Request code the core must drop
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_wr_en      = 1'b0;
    logic               cfg_index      = CFG_NEEDLE_LEN;
    logic [CFG_W-1:0]   cfg_data       = '0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type       = REQ_NEEDLE;
    logic [HADDR_W-1:0] byte_index     = '0;
    logic [7:0]         byte_value     = '0;
    logic [HADDR_W-1:0] start_position = '0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic [1:0]         status;
    logic [HADDR_W-1:0] match_position;
    int                 searches_open;
    int                 failures;

    // Traffic shaping
    int          gap_pct     = 14;
    int          stall_pct   = 86;
    int          item_tally  = 0;
    bit          tally_on    = 1'b0;
    bit          valid_up    = 1'b0;
    int          cycle_count = 0;
    int          rounds      = 0;

    // What the stimulus has put into the stores so far
    int unsigned needle_use  = 0;
    int unsigned hay_use     = 0;
    bit          needle_known [NEEDLE_MAX];
    bit          hay_known    [HAYSTACK_MAX];
    logic [7:0]  needle_copy  [NEEDLE_MAX];
    logic [7:0]  sym_base     = '0;
    logic [7:0]  sym_mask     = 8'hFF;

    horspool_substring_search_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .byte_index     (byte_index),
        .byte_value     (byte_value),
        .start_position (start_position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .match_position (match_position)
    );

    search_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .byte_index     (byte_index),
        .byte_value     (byte_value),
        .start_position (start_position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .match_position (match_position),
        .searches_open  (searches_open),
        .failures       (failures)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stall the result channel at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Byte from the current round's alphabet
    function automatic logic [7:0] pick_byte();
        return sym_base ^ (8'($urandom) & sym_mask);
    endfunction

    // Start offset, mostly inside the haystack in use
    function automatic logic [HADDR_W-1:0] pick_start();
        int roll;

        roll = $urandom_range(99);
        if (roll < 30)
            return '0;
        else if (roll < 80 && hay_use > 0)
            return HADDR_W'($urandom_range(hay_use - 1, 0));
        else
            return HADDR_W'($urandom);
    endfunction

    // Offer one request beat and hold it until taken
    task automatic push_req(input logic [1:0] kind, input logic [HADDR_W-1:0] idx,
                            input logic [7:0] val, input logic [HADDR_W-1:0] from);
        if ($urandom_range(99) < gap_pct)
        begin
            if (valid_up)
            begin
                in_valid <= 1'b0;
                valid_up = 1'b0;
            end
            @(posedge clk);
            while ($urandom_range(99) < gap_pct)
                @(posedge clk);
        end
        in_valid       <= 1'b1;
        valid_up       = 1'b1;
        req_type       <= kind;
        byte_index     <= idx;
        byte_value     <= val;
        start_position <= from;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);

        if (kind == REQ_NEEDLE && idx < NEEDLE_MAX)
        begin
            needle_known[idx] = 1'b1;
            needle_copy[idx]  = val;
        end
        if (kind == REQ_HAYSTACK)
            hay_known[idx] = 1'b1;
        if (tally_on && (kind == REQ_SEARCH || kind == REQ_HAYSTACK ||
                         (kind == REQ_NEEDLE && idx < NEEDLE_MAX)))
            item_tally++;
    endtask

    // Hold off requests until every search has reported
    task automatic drain();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        @(posedge clk);
        while (searches_open != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both length registers while idle, then fill any entry a search could read unset
    task automatic set_lengths(input logic [NLEN_W-1:0] ncfg, input logic [HLEN_W-1:0] hcfg);
        int unsigned k;
        bit          tally_was;

        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_NEEDLE_LEN;
        cfg_data  <= CFG_W'(ncfg);
        @(posedge clk);
        cfg_index <= CFG_HAYSTACK_LEN;
        cfg_data  <= hcfg;
        @(posedge clk);
        cfg_wr_en <= 1'b0;

        needle_use = (ncfg > NEEDLE_MAX) ? NEEDLE_MAX : int'(ncfg);
        hay_use    = (hcfg > HAYSTACK_MAX) ? HAYSTACK_MAX : int'(hcfg);

        tally_was = tally_on;
        tally_on  = 1'b0;
        for (k = 0; k < needle_use; k++)
            if (!needle_known[k])
                push_req(REQ_NEEDLE, HADDR_W'(k), 8'($urandom), '0);
        for (k = 0; k < hay_use; k++)
            if (!hay_known[k])
                push_req(REQ_HAYSTACK, HADDR_W'(k), 8'($urandom), '0);
        tally_on = tally_was;
    endtask

    // Copy the current needle into the haystack so that searches can hit
    task automatic plant_needle();
        int unsigned at;
        int unsigned k;

        if (needle_use > 0 && needle_use <= hay_use)
        begin
            at = $urandom_range(hay_use - needle_use, 0);
            for (k = 0; k < needle_use; k++)
                push_req(REQ_HAYSTACK, HADDR_W'(at + k), needle_copy[k], HADDR_W'($urandom));
        end
    endtask

    // One round: new lengths, a fresh needle and haystack content, then mixed traffic
    task automatic run_round(input int r);
        int                roll;
        int                ops;
        int unsigned       k;
        int unsigned       at;
        int unsigned       span;
        bit                wide;
        logic [NLEN_W-1:0] ncfg;
        logic [HLEN_W-1:0] hcfg;

        wide = 1'b0;
        roll = $urandom_range(99);
        if (r == 0)
        begin
            // both lengths above the store depths
            ncfg = '1;
            hcfg = '1;
            wide = 1'b1;
        end
        else if (r == 1)
        begin
            ncfg = NLEN_W'(NEEDLE_MAX);
            hcfg = HLEN_W'(HAYSTACK_MAX);
            wide = 1'b1;
        end
        else if (r == 2)
        begin
            ncfg = NLEN_W'(1);
            hcfg = HLEN_W'(1);
        end
        else if (roll < 3)
        begin
            ncfg = '0;
            hcfg = HLEN_W'($urandom_range(64, 1));
        end
        else if (roll < 6)
        begin
            ncfg = NLEN_W'($urandom_range(8, 1));
            hcfg = '0;
        end
        else if (roll < 9)
        begin
            ncfg = NLEN_W'($urandom_range(127, 16));
            hcfg = HLEN_W'($urandom_range(8191, 2048));
            wide = 1'b1;
        end
        else if (roll < 25)
        begin
            ncfg = NLEN_W'($urandom_range(64, 9));
            hcfg = HLEN_W'($urandom_range(200, 16));
        end
        else
        begin
            ncfg = NLEN_W'($urandom_range(8, 1));
            hcfg = HLEN_W'($urandom_range(96, 1));
        end
        set_lengths(ncfg, hcfg);

        // Narrow alphabets give repeats and near misses; keep long needles cheap
        sym_base = 8'($urandom);
        case ($urandom_range(2))
            0:       sym_mask = 8'h01;
            1:       sym_mask = 8'h03;
            default: sym_mask = 8'hFF;
        endcase
        if (wide || needle_use > 8)
            sym_mask = 8'hFF;

        for (k = 0; k < needle_use; k++)
            push_req(REQ_NEEDLE, HADDR_W'(k), pick_byte(), HADDR_W'($urandom));

        if (hay_use > 0)
        begin
            at   = $urandom_range(hay_use - 1, 0);
            span = $urandom_range(48, 4);
            for (k = 0; k < span && at + k < hay_use; k++)
                push_req(REQ_HAYSTACK, HADDR_W'(at + k), pick_byte(), HADDR_W'($urandom));
        end
        plant_needle();

        ops = wide ? 4 : $urandom_range(20, 6);
        for (int j = 0; j < ops; j++)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                push_req(REQ_SEARCH, HADDR_W'($urandom), 8'($urandom), pick_start());
            end
            else if (roll < 70)
            begin
                if ($urandom_range(99) < 85 && hay_use > 0)
                    at = $urandom_range(hay_use - 1, 0);
                else
                    at = $urandom_range(HAYSTACK_MAX - 1, 0);
                push_req(REQ_HAYSTACK, HADDR_W'(at),
                         ($urandom_range(3) == 0) ? 8'($urandom) : pick_byte(),
                         HADDR_W'($urandom));
            end
            else if (roll < 80)
            begin
                if ($urandom_range(99) < 80 && needle_use > 0)
                    at = $urandom_range(needle_use - 1, 0);
                else
                    at = $urandom_range(HAYSTACK_MAX - 1, 0);
                push_req(REQ_NEEDLE, HADDR_W'(at), pick_byte(), HADDR_W'($urandom));
            end
            else if (roll < 88)
            begin
                plant_needle();
            end
            else if (roll < 95)
            begin
                push_req(REQ_UNUSED, HADDR_W'($urandom), 8'($urandom), HADDR_W'($urandom));
            end
            else
            begin
                drain();
            end
        end
        push_req(REQ_SEARCH, '0, '0, '0);
    endtask

    // Reset, directed cases, random rounds, verdict
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both lengths zero straight out of reset; dropped beats alongside
        push_req(REQ_SEARCH, '0, '0, '0);
        push_req(REQ_UNUSED, '1, '1, '1);
        push_req(REQ_NEEDLE, '1, 8'hFF, '0);

        // Needle set, haystack still unset
        set_lengths(NLEN_W'(3), '0);
        push_req(REQ_NEEDLE, HADDR_W'(0), 8'hFF, '0);
        push_req(REQ_NEEDLE, HADDR_W'(1), 8'h00, '0);
        push_req(REQ_NEEDLE, HADDR_W'(2), 8'hFF, '0);
        push_req(REQ_SEARCH, '0, '0, '0);

        // Alternating haystack: hits at odd offsets, then windows past the end
        set_lengths(NLEN_W'(3), HLEN_W'(8));
        for (int k = 0; k < 8; k++)
            push_req(REQ_HAYSTACK, HADDR_W'(k), k[0] ? 8'hFF : 8'h00, '0);
        push_req(REQ_SEARCH, '0, '0, HADDR_W'(0));
        push_req(REQ_SEARCH, '0, '0, HADDR_W'(2));
        push_req(REQ_SEARCH, '0, '0, HADDR_W'(4));
        push_req(REQ_SEARCH, '0, '0, HADDR_W'(6));
        push_req(REQ_SEARCH, '0, '0, '1);
        push_req(REQ_HAYSTACK, '1, 8'h00, '0);

        // Needle no longer present: the search runs off the end
        push_req(REQ_NEEDLE, HADDR_W'(1), 8'h7F, '0);
        push_req(REQ_SEARCH, '0, '0, '0);

        // Random rounds, idling pattern by thirds
        tally_on   = 1'b1;
        item_tally = 0;
        while (item_tally < RANDOM_ITEMS)
        begin
            if (item_tally < RANDOM_ITEMS / 3)
            begin
                gap_pct   = 14;
                stall_pct = 86;
            end
            else if (item_tally < 2 * RANDOM_ITEMS / 3)
            begin
                gap_pct   = 86;
                stall_pct = 14;
            end
            else
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            run_round(rounds);
            rounds++;
        end

        drain();
        repeat (16) @(posedge clk);
        if (failures == 0 && searches_open == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
